// ===== rtl/dds_pkg.sv =====
// Shared types, constants and width helpers for the decimal digit square root block.
package dds_pkg;

   localparam int MAX_DIGITS_DEF = 8;

   localparam int GROUP_W   = 7;
   localparam int DIGIT_W   = 4;
   localparam int PARTIAL_W = 27;
   localparam int REMOUT_W  = 28;
   localparam int LIMIT_W   = 4;
   localparam int MUL_B_W   = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;
   localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 4'd1;
   localparam logic [GROUP_W-1:0] GROUP_MAX   = 7'd99;
   localparam logic [DIGIT_W-1:0] DIGIT_TOP   = 4'd9;
   localparam logic [DIGIT_W-1:0] DIGIT_ZERO  = 4'd0;
   localparam logic [MUL_B_W-1:0] C_HUNDRED   = 7'd100;
   localparam logic [MUL_B_W-1:0] C_TWENTY    = 7'd20;
   localparam logic [MUL_B_W-1:0] C_TEN       = 7'd10;

   typedef struct packed {
      logic [GROUP_W-1:0] pair_group;
      logic               start_req;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0]   root_digit;
      logic [PARTIAL_W-1:0] partial_root;
      logic [REMOUT_W-1:0]  new_remainder;
      logic                 last;
   } rsp_type;

   // Operation applied to the shared multiplier in a given cycle
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_LOAD  = 3'd1,
      OP_TRIAL = 3'd2,
      OP_BASE  = 3'd3,
      OP_TRY   = 3'd4,
      OP_ROOT  = 3'd5
   } dds_op_type;

   typedef struct packed {
      dds_op_type         op;
      logic               clear;
      logic [GROUP_W-1:0] group;
   } dds_ctrl_type;

   typedef struct packed {
      logic fit;
      logic rem_zero;
   } dds_stat_type;

   function automatic longint unsigned dds_pow10(input int n);
      longint unsigned v;
      v = 64'd1;
      for (int i = 0; i < n; i++) begin
         v = v * 64'd10;
      end
      return v;
   endfunction

   // Bits for a root of n decimal digits
   function automatic int dds_root_w(input int n);
      return $clog2(dds_pow10(n));
   endfunction

   // Bits for the trial value, remainder and 20*root of an n digit run
   function automatic int dds_work_w(input int n);
      return $clog2(64'd200 * dds_pow10(n - 1));
   endfunction

endpackage

// ===== rtl/decimal_digit_square_root.sv =====
// Top level: sequencer, handshakes, limit register and result register.
// Decimal square root, one root digit per base-100 group. A group is taken when the block
// is idle; the next root digit is found by trying candidates 9, 8, ... 0 on a single shared
// multiplier, one candidate per clock. Together with the trial, base and root update steps
// on the same multiplier, a group holds the block from acceptance until its result reaches
// the output register, after which the next group is taken. A group arriving without a
// start flag after the final result of a run is consumed and gives no result. A finished
// result waits in its own register, so a stalled result side only holds the block when a
// second result is ready. The digit limit register may be written at any time the block
// is idle.
module decimal_digit_square_root #(
   parameter int MAX_DIGITS = dds_pkg::MAX_DIGITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dds_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dds_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dds_pkg::LIMIT_W-1:0]     csr_wdata
);
   import dds_pkg::*;

   localparam int ROOT_W = dds_root_w(MAX_DIGITS);
   localparam int WORK_W = dds_work_w(MAX_DIGITS);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(MAX_DIGITS);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_TRIAL = 6'b000010,
      S_BASE  = 6'b000100,
      S_TRY   = 6'b001000,
      S_ROOT  = 6'b010000,
      S_EMIT  = 6'b100000
   } dds_state_type;

   dds_state_type       state_ff, state_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [LIMIT_W-1:0]  done_ff, done_in;
   logic                finished_ff, finished_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   dds_ctrl_type        ctrl;
   dds_stat_type        stat;
   logic [DIGIT_W-1:0]  digit;
   logic [ROOT_W-1:0]   root;
   logic [WORK_W-1:0]   rem;

   logic                req_take;
   logic                out_free;
   logic [LIMIT_W-1:0]  limit_eff;
   logic [LIMIT_W-1:0]  done_next;
   logic                last;

   dds_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock (clock),
      .ctrl  (ctrl),
      .stat  (stat),
      .digit (digit),
      .root  (root),
      .rem   (rem)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = (state_ff == S_IDLE);

   always_comb begin
      if (limit_ff < LIMIT_MIN) begin
         limit_eff = LIMIT_MIN;
      end else if (limit_ff > LIMIT_MAX) begin
         limit_eff = LIMIT_MAX;
      end else begin
         limit_eff = limit_ff;
      end
   end

   assign done_next = done_ff + 1'b1;
   assign last      = stat.rem_zero || (done_next >= limit_eff);

   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      finished_in  = finished_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      limit_in     = (csr_valid && csr_ready) ? csr_wdata : limit_ff;
      ctrl.op      = OP_NONE;
      ctrl.clear   = req_data.start_req;
      ctrl.group   = req_data.pair_group;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_data.start_req) begin
                  done_in     = '0;
                  finished_in = 1'b0;
               end
               // drop a group that arrives outside a run
               if (req_data.start_req || !finished_ff) begin
                  ctrl.op  = OP_LOAD;
                  state_in = S_TRIAL;
               end
            end
         end
         S_TRIAL: begin
            ctrl.op  = OP_TRIAL;
            state_in = S_BASE;
         end
         S_BASE: begin
            ctrl.op  = OP_BASE;
            state_in = S_TRY;
         end
         S_TRY: begin
            ctrl.op = OP_TRY;
            if (stat.fit) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            ctrl.op  = OP_ROOT;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold until the result register is free
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.root_digit    = digit;
               rsp_data_in.partial_root  = PARTIAL_W'(root);
               rsp_data_in.new_remainder = REMOUT_W'(rem);
               rsp_data_in.last          = last;
               done_in                   = done_next;
               finished_in               = last;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= LIMIT_RESET;
         done_ff      <= '0;
         finished_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         done_ff      <= done_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/dds_datapath.sv =====
// Root, remainder and trial registers around one shared multiplier.
module dds_datapath #(
   parameter int MAX_DIGITS = dds_pkg::MAX_DIGITS_DEF
) (
   input  logic                                         clock,
   input  dds_pkg::dds_ctrl_type                        ctrl,
   output dds_pkg::dds_stat_type                        stat,
   output logic [dds_pkg::DIGIT_W-1:0]                  digit,
   output logic [dds_pkg::dds_root_w(MAX_DIGITS)-1:0]   root,
   output logic [dds_pkg::dds_work_w(MAX_DIGITS)-1:0]   rem
);
   import dds_pkg::*;

   localparam int ROOT_W = dds_root_w(MAX_DIGITS);
   localparam int WORK_W = dds_work_w(MAX_DIGITS);
   localparam int PROD_W = WORK_W + MUL_B_W;

   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [WORK_W-1:0]  rem_ff, rem_in;
   logic [WORK_W-1:0]  trial_ff, trial_in;
   logic [WORK_W-1:0]  base_ff, base_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;

   logic [WORK_W-1:0]  mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;
   logic               fit;

   always_comb begin
      case (ctrl.op)
         OP_TRIAL: begin
            mul_a = rem_ff;
            mul_b = C_HUNDRED;
         end
         OP_BASE: begin
            mul_a = WORK_W'(root_ff);
            mul_b = C_TWENTY;
         end
         OP_TRY: begin
            mul_a = base_ff + WORK_W'(digit_ff);
            mul_b = MUL_B_W'(digit_ff);
         end
         OP_ROOT: begin
            mul_a = WORK_W'(root_ff);
            mul_b = C_TEN;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign fit  = (prod <= PROD_W'(trial_ff)) || (digit_ff == DIGIT_ZERO);

   always_comb begin
      root_in  = root_ff;
      rem_in   = rem_ff;
      trial_in = trial_ff;
      base_in  = base_ff;
      group_in = group_ff;
      digit_in = digit_ff;
      case (ctrl.op)
         OP_LOAD: begin
            group_in = (ctrl.group > GROUP_MAX) ? GROUP_MAX : ctrl.group;
            if (ctrl.clear) begin
               root_in = '0;
               rem_in  = '0;
            end
         end
         OP_TRIAL: begin
            trial_in = WORK_W'(prod) + WORK_W'(group_ff);
         end
         OP_BASE: begin
            base_in  = WORK_W'(prod);
            digit_in = DIGIT_TOP;
         end
         OP_TRY: begin
            // keep the first candidate from the top whose product fits
            if (fit) begin
               rem_in = trial_ff - WORK_W'(prod);
            end else begin
               digit_in = digit_ff - 1'b1;
            end
         end
         OP_ROOT: begin
            root_in = ROOT_W'(prod + PROD_W'(digit_ff));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      root_ff  <= root_in;
      rem_ff   <= rem_in;
      trial_ff <= trial_in;
      base_ff  <= base_in;
      group_ff <= group_in;
      digit_ff <= digit_in;
   end

   assign stat.fit      = fit;
   assign stat.rem_zero = (rem_ff == '0);
   assign digit         = digit_ff;
   assign root          = root_ff;
   assign rem           = rem_ff;

endmodule

// ===== rtl/dds_checker.sv =====
// Port-level checks for the decimal digit square root block, bound to the top level.
module dds_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input dds_pkg::req_type            req_data,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input dds_pkg::rsp_type            rsp_data,
   input logic                        csr_valid,
   input logic                        csr_ready
);
   import dds_pkg::*;

   // a stalled transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a started group keeps the block busy for its digit search
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.start_req |=> req_stall ##1 req_stall)
      else $error("block took a group during a digit search");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.root_digit <= DIGIT_TOP)
      else $error("root digit above nine");

   // an exact root always ends the run
   a_zero_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.new_remainder == '0) |-> rsp_data.last)
      else $error("zero remainder without last");

   // a limit write lands only while the block is idle
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !req_stall)
      else $error("limit written during a digit search");

endmodule

bind decimal_digit_square_root dds_checker u_dds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
